>>> rtl/mtpc_pkg.sv
// ----------------------------------------------------------------------------
// mtpc_pkg
// Shared types and fixed constants of the tape port controller.
// ----------------------------------------------------------------------------
package mtpc_pkg;

    localparam int BLOCK_BYTES  = 543;
    localparam int HEADER_BYTES = 15;
    localparam int MARK_ROWS    = 512;

    localparam logic [7:0] MARK_OK    = 8'hff;
    localparam logic [7:0] STAT_SYNC  = 8'hf9;
    localparam logic [7:0] STAT_WP    = 8'hfe;
    localparam logic [3:0] CNT_RELOAD = 4'd15;
    localparam logic [3:0] PRE_MARKS  = 4'd12;

    typedef enum logic [3:0] {
        OP_STATUS  = 4'd0,
        OP_CONTROL = 4'd1,
        OP_RD_BYTE = 4'd2,
        OP_WR_BYTE = 4'd3,
        OP_INSERT  = 4'd4,
        OP_EJECT   = 4'd5,
        OP_IMG_WR  = 4'd6,
        OP_IMG_RD  = 4'd7,
        OP_SAVED   = 4'd8
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FILL
    } t_state;

endpackage

>>> rtl/mtpc_ram.sv
// ----------------------------------------------------------------------------
// mtpc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mtpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/microdrive_tape_port_controller.sv
// ----------------------------------------------------------------------------
// microdrive_tape_port_controller
// Tape drive controller for up to eight drives over a tape byte store and a
// preamble mark store, both in synchronous RAM.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata fields (lowest bit up)
//  s_axis   | in  | op 4, write_byte 8, drive 3, image_addr 18, length_blocks 8,
//           |     | write_protect 1, zero pad 6
//  m_axis   | out | read_byte 8, motor_mask 8, inserted_mask 8, modified_mask 8,
//           |     | pending_save_mask 8
//
//  A word is handled as a RAM read of tape and mark when accepted, then a
//  step that modifies, writes back and loads the output register.
//  An accepted insert then fills 2 * length_blocks mark entries (length_blocks
//  capped at MAX_BLOCKS), one a cycle, with s_axis_tready low.
//  A full output register holds the modify step until m_axis_tready.
//  Reset is synchronous and clears all drive state; the RAMs are not cleared.
// ----------------------------------------------------------------------------
module microdrive_tape_port_controller #(
    parameter int DRIVES     = 8,
    parameter int MAX_BLOCKS = 254
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // op, write_byte, drive, image_addr,
                                        // length_blocks, write_protect
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // read_byte, motor_mask, inserted_mask,
                                        // modified_mask, pending_save_mask
);
    import mtpc_pkg::*;

    localparam int DW     = (DRIVES > 1) ? $clog2(DRIVES) : 1;
    localparam int REGION = MAX_BLOCKS * BLOCK_BYTES;
    localparam int TDEPTH = DRIVES * REGION;
    localparam int TAW    = $clog2(TDEPTH);
    localparam int MDEPTH = DRIVES * MARK_ROWS;
    localparam int MAW    = $clog2(MDEPTH);

    function automatic logic [17:0] step_head(input logic [7:0] blk, input logic [9:0] off,
                                              input logic [7:0] blocks);
        logic [7:0] nb;
        logic [9:0] no;
        nb = blk;
        no = off + 10'd1;
        if (off == 10'(BLOCK_BYTES - 1)) begin
            nb = blk + 8'd1;
            no = '0;
        end
        if (nb >= blocks) begin
            nb = '0;
            no = '0;
        end
        return {nb, no};
    endfunction

    function automatic logic [17:0] align_head(input logic [7:0] blk, input logic [9:0] off,
                                               input logic [7:0] blocks);
        logic [7:0] nb;
        logic [9:0] no;
        nb = blk;
        no = off;
        if (off != '0 && off != 10'(HEADER_BYTES)) begin
            if (off < 10'(HEADER_BYTES)) begin
                no = 10'(HEADER_BYTES);
            end else begin
                nb = blk + 8'd1;
                no = '0;
            end
            if (nb >= blocks) begin
                nb = '0;
                no = '0;
            end
        end
        return {nb, no};
    endfunction

    // input fields
    logic [3:0]  w_op;
    logic [7:0]  w_wb;
    logic [2:0]  w_drive;
    logic [17:0] w_addr;
    assign w_op    = s_axis_tdata[3:0];
    assign w_wb    = s_axis_tdata[11:4];
    assign w_drive = s_axis_tdata[14:12];
    assign w_addr  = s_axis_tdata[32:15];

    t_state r_state, n_state;

    logic [3:0]     r_op;
    logic [7:0]     r_wb;
    logic [2:0]     r_drv;
    logic           r_addr_ok;
    logic [7:0]     r_len;
    logic           r_wp_in;
    logic [TAW-1:0] r_taddr;
    logic [MAW-1:0] r_maddr;

    logic [DRIVES-1:0] r_motor, n_motor;
    logic              r_clk_lvl, n_clk_lvl;
    logic [7:0]  r_blk [DRIVES];
    logic [7:0]  n_blk [DRIVES];
    logic [9:0]  r_off [DRIVES];
    logic [9:0]  n_off [DRIVES];
    logic [9:0]  r_tc [DRIVES];
    logic [9:0]  n_tc [DRIVES];
    logic [3:0]  r_gap [DRIVES];
    logic [3:0]  n_gap [DRIVES];
    logic [3:0]  r_sync [DRIVES];
    logic [3:0]  n_sync [DRIVES];
    logic [7:0]  r_last [DRIVES];
    logic [7:0]  n_last [DRIVES];
    logic [7:0]  r_blocks [DRIVES];
    logic [7:0]  n_blocks [DRIVES];
    logic [DRIVES-1:0] r_indata, n_indata;
    logic [DRIVES-1:0] r_ins, n_ins;
    logic [DRIVES-1:0] r_pend, n_pend;
    logic [DRIVES-1:0] r_mod, n_mod;
    logic [DRIVES-1:0] r_wp, n_wp;

    logic [7:0] r_fk;
    logic       r_fph;
    logic [2:0] r_fdrv;
    logic [7:0] r_flen;
    logic       n_fill;
    logic [7:0] n_flen;

    logic        r_out_valid;
    logic [39:0] r_out;
    logic [7:0]  n_ret;

    logic          a_ok;
    logic [DW-1:0] a_idx;
    logic          w_accept, w_commit, w_fill_done;
    logic [TAW-1:0] w_taddr;
    logic [MAW-1:0] w_maddr;
    logic [7:0]     tape_rd, mark_rd;
    logic           tape_we, mark_we;
    logic [MAW-1:0] mark_waddr;
    logic [7:0]     mark_wdata;
    logic [7:0]     n_mark;
    logic           n_mark_we;

    always_comb begin
        a_ok  = 1'b0;
        a_idx = '0;
        for (int d = DRIVES - 1; d >= 0; d--) begin
            if (r_motor[d]) begin
                a_ok  = 1'b1;
                a_idx = DW'(d);
            end
        end
    end

    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_commit    = (r_state == ST_EXEC) && (!r_out_valid || m_axis_tready);
    assign w_fill_done = r_fph && (r_fk == r_flen - 8'd1);

    always_comb begin
        if (w_op == OP_IMG_WR || w_op == OP_IMG_RD) begin
            w_taddr = TAW'(w_drive) * TAW'(REGION) + TAW'(w_addr);
        end else begin
            w_taddr = TAW'(a_idx) * TAW'(REGION)
                    + TAW'(r_blk[a_idx]) * TAW'(BLOCK_BYTES) + TAW'(r_off[a_idx]);
        end
        w_maddr = (MAW'(a_idx) << 9) + MAW'({r_indata[a_idx], r_blk[a_idx]});
    end

    mtpc_ram #(.WIDTH(8), .DEPTH(TDEPTH)) u_tape (
        .i_clk   (i_clk),
        .i_we    (tape_we),
        .i_waddr (r_taddr),
        .i_wdata (r_wb),
        .i_re    (w_accept),
        .i_raddr (w_taddr),
        .o_rdata (tape_rd)
    );

    mtpc_ram #(.WIDTH(8), .DEPTH(MDEPTH)) u_mark (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_re    (w_accept),
        .i_raddr (w_maddr),
        .o_rdata (mark_rd)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_commit) begin
                    n_state = n_fill ? ST_FILL : ST_IDLE;
                end
            end
            ST_FILL: begin
                if (w_fill_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        tape_we       = 1'b0;
        mark_we       = 1'b0;
        mark_waddr    = r_maddr;
        mark_wdata    = n_mark;
        if (r_state == ST_FILL) begin
            mark_we    = 1'b1;
            mark_waddr = (MAW'(r_fdrv) << 9) + MAW'({r_fph, r_fk});
            mark_wdata = MARK_OK;
        end else if (w_commit) begin
            mark_we = n_mark_we;
            tape_we = (r_op == OP_IMG_WR && int'(r_drv) < DRIVES && r_addr_ok)
                   || (r_op == OP_WR_BYTE && a_ok && r_ins[a_idx]
                       && r_blk[a_idx] < 8'(MAX_BLOCKS)
                       && r_tc[a_idx] > 10'd11
                       && {1'b0, r_tc[a_idx]}
                          < ({1'b0, (r_indata[a_idx] ? 10'd528 : 10'(HEADER_BYTES))}
                             + 11'd12));
        end
    end

    always_comb begin
        logic          drv_ok;
        logic [DW-1:0] dd;
        logic [9:0]    maxb;
        logic [9:0]    t;
        logic [17:0]   hp;
        logic          realign;
        drv_ok    = int'(r_drv) < DRIVES;
        dd        = r_drv[DW-1:0];
        hp        = '0;
        realign   = 1'b0;
        n_ret     = 8'hff;
        n_mark    = mark_rd;
        n_mark_we = 1'b0;
        n_fill    = 1'b0;
        n_flen    = r_len;
        n_motor   = r_motor;
        n_clk_lvl = r_clk_lvl;
        n_indata  = r_indata;
        n_ins     = r_ins;
        n_pend    = r_pend;
        n_mod     = r_mod;
        n_wp      = r_wp;
        for (int d = 0; d < DRIVES; d++) begin
            n_blk[d]    = r_blk[d];
            n_off[d]    = r_off[d];
            n_tc[d]     = r_tc[d];
            n_gap[d]    = r_gap[d];
            n_sync[d]   = r_sync[d];
            n_last[d]   = r_last[d];
            n_blocks[d] = r_blocks[d];
        end
        maxb = r_indata[a_idx] ? 10'd528 : 10'(HEADER_BYTES);
        t    = r_tc[a_idx];

        case (r_op)
            OP_STATUS: begin
                if (a_ok && r_ins[a_idx]) begin
                    if (mark_rd == MARK_OK) begin
                        if (r_gap[a_idx] != '0) begin
                            n_gap[a_idx] = r_gap[a_idx] - 4'd1;
                        end else begin
                            n_ret = n_ret & STAT_SYNC;
                            if (r_sync[a_idx] != '0) begin
                                n_sync[a_idx] = r_sync[a_idx] - 4'd1;
                            end else begin
                                n_gap[a_idx]  = CNT_RELOAD;
                                n_sync[a_idx] = CNT_RELOAD;
                            end
                        end
                    end
                    if (r_wp[a_idx]) begin
                        n_ret = n_ret & STAT_WP;
                    end
                end
                realign = 1'b1;
            end
            OP_CONTROL: begin
                if (!r_wb[1] && r_clk_lvl) begin
                    n_motor = DRIVES'({r_motor, !r_wb[0]});
                end
                n_clk_lvl = r_wb[1];
                realign   = 1'b1;
            end
            OP_RD_BYTE: begin
                if (a_ok && r_ins[a_idx]) begin
                    if (t < maxb) begin
                        n_last[a_idx] = (r_blk[a_idx] < 8'(MAX_BLOCKS)) ? tape_rd : 8'h00;
                        hp = step_head(r_blk[a_idx], r_off[a_idx], r_blocks[a_idx]);
                        n_blk[a_idx] = hp[17:10];
                        n_off[a_idx] = hp[9:0];
                    end
                    if (t != 10'h3ff) begin
                        n_tc[a_idx] = t + 10'd1;
                    end
                    n_ret = n_last[a_idx];
                end
            end
            OP_WR_BYTE: begin
                if (a_ok && r_ins[a_idx]) begin
                    if (t == 10'd0 && r_wb == 8'h00) begin
                        n_mark    = 8'h01;
                        n_mark_we = 1'b1;
                    end else if (t >= 10'd1 && t <= 10'd9 && r_wb == 8'h00) begin
                        n_mark    = mark_rd + 8'd1;
                        n_mark_we = 1'b1;
                    end else if (t >= 10'd10 && t <= 10'd11 && r_wb == 8'hff) begin
                        n_mark    = mark_rd + 8'd1;
                        n_mark_we = 1'b1;
                    end else if (t == 10'd12 && mark_rd == 8'(PRE_MARKS)) begin
                        n_mark    = MARK_OK;
                        n_mark_we = 1'b1;
                    end
                    if (t > 10'd11 && {1'b0, t} < ({1'b0, maxb} + 11'd12)) begin
                        hp = step_head(r_blk[a_idx], r_off[a_idx], r_blocks[a_idx]);
                        n_blk[a_idx] = hp[17:10];
                        n_off[a_idx] = hp[9:0];
                        n_mod[a_idx] = 1'b1;
                    end
                    if (t != 10'h3ff) begin
                        n_tc[a_idx] = t + 10'd1;
                    end
                end
            end
            OP_INSERT: begin
                if (drv_ok && !r_ins[dd] && !r_pend[dd]) begin
                    n_flen       = (r_len > 8'(MAX_BLOCKS)) ? 8'(MAX_BLOCKS) : r_len;
                    n_blocks[dd] = n_flen;
                    n_ins[dd]    = 1'b1;
                    n_wp[dd]     = r_wp_in;
                    n_fill       = (n_flen != '0);
                    realign      = 1'b1;
                end
            end
            OP_EJECT: begin
                if (drv_ok && r_ins[dd]) begin
                    n_ins[dd] = 1'b0;
                    if (r_mod[dd]) begin
                        n_pend[dd] = 1'b1;
                    end
                end
            end
            OP_IMG_RD: begin
                if (drv_ok && r_addr_ok) begin
                    n_ret = tape_rd;
                end
            end
            OP_SAVED: begin
                if (drv_ok) begin
                    n_pend[dd] = 1'b0;
                    n_mod[dd]  = 1'b0;
                end
            end
            default: begin
            end
        endcase

        if (realign) begin
            for (int d = 0; d < DRIVES; d++) begin
                hp          = align_head(n_blk[d], n_off[d], n_blocks[d]);
                n_blk[d]    = hp[17:10];
                n_off[d]    = hp[9:0];
                n_tc[d]     = '0;
                n_indata[d] = (hp[9:0] != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_motor     <= '0;
            r_clk_lvl   <= 1'b0;
            r_indata    <= '0;
            r_ins       <= '0;
            r_pend      <= '0;
            r_mod       <= '0;
            r_wp        <= '0;
            r_fk        <= '0;
            r_fph       <= 1'b0;
            for (int d = 0; d < DRIVES; d++) begin
                r_blk[d]    <= '0;
                r_off[d]    <= '0;
                r_tc[d]     <= '0;
                r_gap[d]    <= CNT_RELOAD;
                r_sync[d]   <= CNT_RELOAD;
                r_last[d]   <= '0;
                r_blocks[d] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_out_valid <= 1'b1;
                r_motor     <= n_motor;
                r_clk_lvl   <= n_clk_lvl;
                r_indata    <= n_indata;
                r_ins       <= n_ins;
                r_pend      <= n_pend;
                r_mod       <= n_mod;
                r_wp        <= n_wp;
                r_fk        <= '0;
                r_fph       <= 1'b0;
                for (int d = 0; d < DRIVES; d++) begin
                    r_blk[d]    <= n_blk[d];
                    r_off[d]    <= n_off[d];
                    r_tc[d]     <= n_tc[d];
                    r_gap[d]    <= n_gap[d];
                    r_sync[d]   <= n_sync[d];
                    r_last[d]   <= n_last[d];
                    r_blocks[d] <= n_blocks[d];
                end
            end else begin
                if (m_axis_tready) begin
                    r_out_valid <= 1'b0;
                end
                if (r_state == ST_FILL) begin
                    if (r_fk == r_flen - 8'd1) begin
                        r_fk  <= '0;
                        r_fph <= 1'b1;
                    end else begin
                        r_fk <= r_fk + 8'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= w_op;
            r_wb      <= w_wb;
            r_drv     <= w_drive;
            r_addr_ok <= int'(w_addr) < REGION;
            r_len     <= s_axis_tdata[40:33];
            r_wp_in   <= s_axis_tdata[41];
            r_taddr   <= w_taddr;
            r_maddr   <= w_maddr;
        end
        if (w_commit) begin
            r_out  <= {8'(n_pend), 8'(n_mod), 8'(n_ins), 8'(n_motor), n_ret};
            r_fdrv <= r_drv;
            r_flen <= n_flen;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule
